FILE: rtl/gledc_pkg.sv
// Shared types and constants for the grouped lamp blink controller.
`timescale 1ns / 1ps
`default_nettype none
package gledc_pkg;

  localparam int LAMP_COUNT = 5;
  localparam int GROUP_W = 8;
  localparam int TIME_W = 8;
  localparam int ACTION_W = 3;
  localparam int CFG_INDEX_W = 3;

  localparam logic [TIME_W-1:0] BLINK_STOPPED = 8'h81;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LIGHT  = 3'd0,
    ACT_DARKEN = 3'd1,
    ACT_BLINK  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_TICK   = 3'd4
  } action_t;

  typedef struct packed {
    action_t               action;
    logic                  hit;
    logic [TIME_W-1:0]     on_time;
    logic [TIME_W-1:0]     off_time;
  } lamp_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/gledc_lamp.sv
// State and per-item update of one lamp.
`timescale 1ns / 1ps
`default_nettype none
module gledc_lamp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire gledc_pkg::lamp_cmd_t  cmd,
  output logic                       lit_nxt
);

  logic                            lit_r;
  logic [gledc_pkg::TIME_W-1:0]    phase_r;
  logic [gledc_pkg::TIME_W-1:0]    phase_nxt;
  logic [gledc_pkg::TIME_W-1:0]    on_r;
  logic [gledc_pkg::TIME_W-1:0]    on_nxt;
  logic [gledc_pkg::TIME_W-1:0]    off_r;
  logic [gledc_pkg::TIME_W-1:0]    off_nxt;
  logic [gledc_pkg::TIME_W-1:0]    count_dec;
  logic [gledc_pkg::TIME_W:0]      count_ext;
  logic [gledc_pkg::TIME_W:0]      reload_bound;

  assign count_dec    = phase_r - 8'd1;
  assign count_ext    = {count_dec[gledc_pkg::TIME_W-1], count_dec};
  assign reload_bound = 9'd0 - {off_r[gledc_pkg::TIME_W-1], off_r};

  always_comb begin
    lit_nxt   = lit_r;
    phase_nxt = phase_r;
    on_nxt    = on_r;
    off_nxt   = off_r;
    case (cmd.action)
      gledc_pkg::ACT_LIGHT: begin
        if (cmd.hit) begin
          lit_nxt = 1'b1;
        end
      end
      gledc_pkg::ACT_DARKEN: begin
        if (cmd.hit) begin
          lit_nxt = 1'b0;
        end
      end
      gledc_pkg::ACT_BLINK: begin
        if (cmd.hit) begin
          on_nxt  = cmd.on_time;
          off_nxt = cmd.off_time;
        end
      end
      gledc_pkg::ACT_STOP: begin
        if (cmd.hit) begin
          on_nxt  = gledc_pkg::BLINK_STOPPED;
          lit_nxt = 1'b0;
        end
      end
      gledc_pkg::ACT_TICK: begin
        if (on_r != gledc_pkg::BLINK_STOPPED) begin
          phase_nxt = count_dec;
          if (!count_dec[gledc_pkg::TIME_W-1] && (count_dec != '0)) begin
            lit_nxt = 1'b1;
          end else begin
            lit_nxt = 1'b0;
            if ($signed(count_ext) <= $signed(reload_bound)) begin
              phase_nxt = on_r + 8'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r   <= 1'b0;
      phase_r <= '0;
      on_r    <= gledc_pkg::BLINK_STOPPED;
      off_r   <= gledc_pkg::BLINK_STOPPED;
    end else if (en) begin
      lit_r   <= lit_nxt;
      phase_r <= phase_nxt;
      on_r    <= on_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/grouped_led_blink_controller_unit.sv
// Top level of the grouped lamp blink controller.
//
//   Channel  Ports                                       Moves
//   in       in_valid/in_ready, action group on off      one command or tick
//   out      out_valid/out_ready, lamp_levels            lamp mask after each item
//   cfg      cfg_valid/cfg_ready, cfg_index cfg_data     group number of one lamp
//
// One item is accepted per cycle while in_ready is high; it is held in the input
// register and then in the result register around the lamp update before its
// result is shown.
// Synchronous active-low reset darkens all lamps and stops all blinking.
// A stalled result holds the result register; the input register still
// takes one further item, then in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module grouped_led_blink_controller_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [gledc_pkg::ACTION_W-1:0]       in_action,
  input  wire logic [gledc_pkg::GROUP_W-1:0]        in_group,
  input  wire logic signed [gledc_pkg::TIME_W-1:0]  in_on_time,
  input  wire logic signed [gledc_pkg::TIME_W-1:0]  in_off_time,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [gledc_pkg::LAMP_COUNT-1:0]          out_lamp_levels,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [gledc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [gledc_pkg::GROUP_W-1:0]        cfg_data
);

  logic                                  item_valid_r;
  gledc_pkg::action_t                    item_action_r;
  logic [gledc_pkg::GROUP_W-1:0]         item_group_r;
  logic [gledc_pkg::TIME_W-1:0]          item_on_r;
  logic [gledc_pkg::TIME_W-1:0]          item_off_r;
  logic                                  out_valid_r;
  logic [gledc_pkg::LAMP_COUNT-1:0]      levels_r;
  logic [gledc_pkg::LAMP_COUNT-1:0]      levels_nxt;
  logic [gledc_pkg::GROUP_W-1:0]         group_of_lamp_r [gledc_pkg::LAMP_COUNT];
  logic                                  advance;
  logic                                  in_fire;

  assign advance   = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_valid_r || !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_lamp_levels = levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_action_r <= gledc_pkg::action_t'(in_action);
      item_group_r  <= in_group;
      item_on_r     <= in_on_time;
      item_off_r    <= in_off_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      levels_r <= levels_nxt;
    end
  end

  for (genvar i = 0; i < gledc_pkg::LAMP_COUNT; i++) begin : g_lamp
    gledc_pkg::lamp_cmd_t cmd;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        group_of_lamp_r[i] <= gledc_pkg::GROUP_W'(i);
      end else if (cfg_valid && cfg_ready &&
                   (cfg_index == gledc_pkg::CFG_INDEX_W'(i))) begin
        group_of_lamp_r[i] <= cfg_data;
      end
    end

    assign cmd.action   = item_action_r;
    assign cmd.hit      = (group_of_lamp_r[i] == item_group_r);
    assign cmd.on_time  = item_on_r;
    assign cmd.off_time = item_off_r;

    gledc_lamp u_lamp (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .cmd     (cmd),
      .lit_nxt (levels_nxt[i])
    );
  end

endmodule
`default_nettype wire

FILE: rtl/gledc_checker.sv
// Port-level assertions for the grouped lamp blink controller and their binding.
`timescale 1ns / 1ps
`default_nettype none
module gledc_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic [gledc_pkg::LAMP_COUNT-1:0]  out_lamp_levels
);

  // A result that is not taken holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lamp_levels))
    else $error("stalled result changed");

  // No result is shown in the cycle after reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // An empty output side always leaves room for an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A new result is shown only for an item accepted into the input register and then moved to the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without accepted item");

endmodule

bind grouped_led_blink_controller_unit gledc_checker u_gledc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_lamp_levels (out_lamp_levels)
);
`default_nettype wire
